/* rtl/mm_pkg.sv */
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared sizes, codes, types and helper functions for the matrix multiply
// block and its sub-modules.
// ----------------------------------------------------------------------------
package mm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 4;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0) + 1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_START   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESULT_ROWS = 2'd0,
      CSR_INNER_LEN   = 2'd1,
      CSR_RESULT_COLS = 2'd2,
      CSR_TRANSPOSE_B = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FINISH
   } state_type;

   // One step of a dot product as it travels down the multiply-accumulate pipe.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_step_type;

   // Highest index for a configured size; zero acts as one, oversize as MAX_DIM.
   function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] size);
      logic [IDX_W-1:0] result;
      if (size == '0) begin
         result = '0;
      end else if (size > DIM_W'(MAX_DIM)) begin
         result = IDX_W'(MAX_DIM - 1);
      end else begin
         result = IDX_W'(size - DIM_W'(1));
      end
      return result;
   endfunction

   // Flat store address of a row and column.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      return ADDR_W'(int'(row) * MAX_DIM + int'(col));
   endfunction

endpackage

/* rtl/mm_ram.sv */
// ----------------------------------------------------------------------------
// Element store
// One matrix of signed words: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mm_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [mm_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [mm_pkg::DATA_W-1:0]  wr_data,
   input  logic [mm_pkg::ADDR_W-1:0]  rd_addr,
   output logic [mm_pkg::DATA_W-1:0]  rd_data
);

   logic [mm_pkg::DATA_W-1:0] mem [mm_pkg::DEPTH];
   logic [mm_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mm_mac.sv */
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Shared signed 32x32 multiplier with a wide accumulator, followed by
// rounding to the fixed-point format and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mm_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  mm_pkg::mac_step_type       step,
   input  logic [mm_pkg::DATA_W-1:0]  a_data,
   input  logic [mm_pkg::DATA_W-1:0]  b_data,
   input  logic                       emit,
   output logic                       done,
   output logic [mm_pkg::DATA_W-1:0]  value
);

   localparam int ACC_W = mm_pkg::ACC_W;
   localparam int DATA_W = mm_pkg::DATA_W;
   localparam int PROD_W = mm_pkg::PROD_W;
   localparam int BIAS_SHIFT = (mm_pkg::FRAC_BITS > 0) ? mm_pkg::FRAC_BITS - 1 : 0;
   localparam logic [ACC_W-1:0] ROUND_BIAS =
      (mm_pkg::FRAC_BITS > 0) ? (ACC_W'(1) << BIAS_SHIFT) : '0;
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   mm_pkg::mac_step_type            s1_ff, s2_ff;
   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [ACC_W-1:0]         acc_ff, acc_in;
   logic                            done_ff, done_in;
   logic [ACC_W-1:0]                rounded;
   logic signed [ACC_W-1:0]         shifted;
   logic [ACC_W-DATA_W:0]           upper;

   // Step flags follow the read data of the stores, then the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= step;
         s2_ff   <= s1_ff;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_data) * $signed(b_data);
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (s2_ff.valid) begin
         if (s2_ff.first) begin
            acc_in = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end else begin
            acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end
   end

   always_comb begin
      done_in = done_ff;
      if (emit) begin
         done_in = 1'b0;
      end else if (s2_ff.valid && s2_ff.last) begin
         done_in = 1'b1;
      end
   end

   // Round half up, then saturate when the bits above the sign are not uniform.
   always_comb begin
      rounded = acc_ff + ROUND_BIAS;
      shifted = $signed(rounded) >>> mm_pkg::FRAC_BITS;
      upper   = shifted[ACC_W-1:DATA_W-1];
      if ((upper == '0) || (upper == '1)) begin
         value = shifted[DATA_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         value = SAT_MIN;
      end else begin
         value = SAT_MAX;
      end
   end

   assign done = done_ff;

endmodule

/* rtl/mm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sequencer
// Takes load and start words, walks rows, columns and inner index over the
// stores, and holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module mm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [mm_pkg::OP_W-1:0]    req_op,
   input  logic [mm_pkg::IDX_W-1:0]   req_row_index,
   input  logic [mm_pkg::IDX_W-1:0]   req_col_index,
   input  logic [mm_pkg::DIM_W-1:0]   result_rows,
   input  logic [mm_pkg::DIM_W-1:0]   inner_len,
   input  logic [mm_pkg::DIM_W-1:0]   result_cols,
   input  logic                       transpose_b,
   output logic                       a_wr_en,
   output logic                       b_wr_en,
   output logic [mm_pkg::ADDR_W-1:0]  wr_addr,
   output logic [mm_pkg::ADDR_W-1:0]  a_rd_addr,
   output logic [mm_pkg::ADDR_W-1:0]  b_rd_addr,
   output mm_pkg::mac_step_type       step,
   input  logic                       mac_done,
   input  logic [mm_pkg::DATA_W-1:0]  mac_value,
   output logic                       emit,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mm_pkg::IDX_W-1:0]   rsp_out_row,
   output logic [mm_pkg::IDX_W-1:0]   rsp_out_col,
   output logic [mm_pkg::DATA_W-1:0]  rsp_out_value,
   output logic                       rsp_last
);

   mm_pkg::state_type            state_ff, state_in;
   logic [mm_pkg::IDX_W-1:0]     r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [mm_pkg::IDX_W-1:0]     nr_last_ff, nk_last_ff, nc_last_ff;
   logic                         trans_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mm_pkg::IDX_W-1:0]     row_ff, col_ff;
   logic [mm_pkg::DATA_W-1:0]    value_ff;
   logic                         last_ff;
   logic                         accept, start, in_range, last_elem;

   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_op == mm_pkg::OP_START);
   assign in_range  = ({1'b0, req_row_index} < mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) &&
                      ({1'b0, req_col_index} < mm_pkg::DIM_W'(mm_pkg::MAX_DIM));
   assign last_elem = (r_ff == nr_last_ff) && (c_ff == nc_last_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mm_pkg::ST_ISSUE;
            end
         end
         mm_pkg::ST_ISSUE: begin
            if (k_ff == nk_last_ff) begin
               state_in = mm_pkg::ST_FINISH;
            end
         end
         mm_pkg::ST_FINISH: begin
            if (emit) begin
               state_in = last_elem ? mm_pkg::ST_IDLE : mm_pkg::ST_ISSUE;
            end
         end
         default: state_in = mm_pkg::ST_IDLE;
      endcase
   end

   // Outputs and counters.
   always_comb begin
      req_stall    = 1'b1;
      step         = '0;
      emit         = 1'b0;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      a_wr_en      = 1'b0;
      b_wr_en      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         mm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            a_wr_en   = accept && in_range && (req_op == mm_pkg::OP_WRITE_A);
            b_wr_en   = accept && in_range && (req_op == mm_pkg::OP_WRITE_B);
            if (start) begin
               r_in = '0;
               c_in = '0;
               k_in = '0;
            end
         end
         mm_pkg::ST_ISSUE: begin
            step.valid = 1'b1;
            step.first = (k_ff == '0);
            step.last  = (k_ff == nk_last_ff);
            k_in       = step.last ? '0 : k_ff + mm_pkg::IDX_W'(1);
         end
         mm_pkg::ST_FINISH: begin
            emit = mac_done && (!rsp_valid_ff || !rsp_stall);
            if (emit) begin
               rsp_valid_in = 1'b1;
               if (c_ff == nc_last_ff) begin
                  c_in = '0;
                  r_in = r_ff + mm_pkg::IDX_W'(1);
               end else begin
                  c_in = c_ff + mm_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign wr_addr   = mm_pkg::addr_of(req_row_index, req_col_index);
   assign a_rd_addr = mm_pkg::addr_of(r_ff, k_ff);
   assign b_rd_addr = trans_ff ? mm_pkg::addr_of(c_ff, k_ff) : mm_pkg::addr_of(k_ff, c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         r_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         nr_last_ff <= mm_pkg::dim_last(result_rows);
         nk_last_ff <= mm_pkg::dim_last(inner_len);
         nc_last_ff <= mm_pkg::dim_last(result_cols);
         trans_ff   <= transpose_b;
      end
      if (emit) begin
         row_ff   <= r_ff;
         col_ff   <= c_ff;
         value_ff <= mac_value;
         last_ff  <= last_elem;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;

endmodule

/* rtl/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// Matrix multiply
// Fixed-point dense matrix product C = A * B or A * transpose(B) on a single
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Load words (op 0 for A, op 1 for B) each write one Q16.16 element into an
// 8x8 store and, while the block is idle, are taken one per cycle with no
// result word. A start word (op 2) multiplies using the sizes held in the
// configuration registers and returns one result word per element of C
// in row-major order, with its row and column and a last flag on the
// final one. While a start word is in progress the request channel stalls.
// For each result element one store read per inner step is issued into
// the single multiplier; then the last read, multiply and accumulate
// drain and the output register loads. A finished element waits while the
// consumer still stalls the previous one, and the next element does not
// begin until it is taken into the output register. Sums are exact in a
// 68-bit accumulator, rounded half up to 16 fraction bits and saturated to
// 32 bits. Sizes of 0 act as 1 and sizes above 8 act as 8. Store entries
// have no reset value: the caller must write every element that a product
// reads. Configuration must only be written while the block is idle.
// ----------------------------------------------------------------------------
module matrix_multiply (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mm_pkg::OP_W-1:0]      req_op,
   input  logic [mm_pkg::IDX_W-1:0]     req_row_index,
   input  logic [mm_pkg::IDX_W-1:0]     req_col_index,
   input  logic signed [mm_pkg::DATA_W-1:0] req_element,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mm_pkg::IDX_W-1:0]     rsp_out_row,
   output logic [mm_pkg::IDX_W-1:0]     rsp_out_col,
   output logic signed [mm_pkg::DATA_W-1:0] rsp_out_value,
   output logic                         rsp_last,
   input  logic                         csr_write,
   input  logic [mm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mm_pkg::CSR_W-1:0]     csr_data
);

   // Configuration registers.
   logic [mm_pkg::DIM_W-1:0] result_rows_ff, inner_len_ff, result_cols_ff;
   logic                     transpose_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         result_rows_ff <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
         inner_len_ff   <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
         result_cols_ff <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
         transpose_b_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            mm_pkg::CSR_RESULT_ROWS: result_rows_ff <= csr_data;
            mm_pkg::CSR_INNER_LEN:   inner_len_ff   <= csr_data;
            mm_pkg::CSR_RESULT_COLS: result_cols_ff <= csr_data;
            mm_pkg::CSR_TRANSPOSE_B: transpose_b_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic                        a_wr_en, b_wr_en, emit, mac_done;
   logic [mm_pkg::ADDR_W-1:0]   wr_addr, a_rd_addr, b_rd_addr;
   logic [mm_pkg::DATA_W-1:0]   a_data, b_data, mac_value, value_out;
   mm_pkg::mac_step_type        step;

   // The sequencer owns both handshakes and the output register.
   mm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .result_rows   (result_rows_ff),
      .inner_len     (inner_len_ff),
      .result_cols   (result_cols_ff),
      .transpose_b   (transpose_b_ff),
      .a_wr_en       (a_wr_en),
      .b_wr_en       (b_wr_en),
      .wr_addr       (wr_addr),
      .a_rd_addr     (a_rd_addr),
      .b_rd_addr     (b_rd_addr),
      .step          (step),
      .mac_done      (mac_done),
      .mac_value     (mac_value),
      .emit          (emit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (value_out),
      .rsp_last      (rsp_last)
   );

   // A and B stores share the write address; each reads one element per cycle.
   mm_ram u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_element),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   mm_ram u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_element),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   // The single multiplier and accumulator, with rounding and saturation.
   mm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .a_data (a_data),
      .b_data (b_data),
      .emit   (emit),
      .done   (mac_done),
      .value  (mac_value)
   );

   assign rsp_out_value = value_out;

endmodule

/* rtl/mm_checker.sv */
// ----------------------------------------------------------------------------
// Matrix multiply port checker
// Assertions on the port behavior of the matrix multiply block, bound to
// the top level.
// ----------------------------------------------------------------------------
module mm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [mm_pkg::OP_W-1:0]      req_op,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [mm_pkg::IDX_W-1:0]     rsp_out_row,
   input logic [mm_pkg::IDX_W-1:0]     rsp_out_col,
   input logic [mm_pkg::DATA_W-1:0]    rsp_out_value,
   input logic                         rsp_last
);

   // A held result word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_value) &&
                                    $stable(rsp_out_row) && $stable(rsp_out_col) &&
                                    $stable(rsp_last)))
      else $error("result word changed while stalled");

   // The request side only stalls after a start word was taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && (req_op == mm_pkg::OP_START)))
      else $error("request stalled without a start word");

   // Once the final element is presented the block is free for new words.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid && rsp_last) |-> !req_stall)
      else $error("request still stalled after the final element");

   // While the block is free, only the final element of a product can be pending.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !req_stall) |-> rsp_last)
      else $error("non-final element pending while idle");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_value (rsp_out_value),
   .rsp_last      (rsp_last)
);
